### hdl/mco_pkg.sv
// shared types and constants for the matrix chain order block
// used by mco_ctrl, mco_dpath and matrix_chain_order_dp_top
`timescale 1ns / 1ps

package mco_pkg;

  localparam int DIM_W    = 16;
  localparam int COST_W   = 52;
  localparam int PROD_W   = 48;
  localparam int SPLIT_W  = 4;
  localparam int TSPLIT_W = 5;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_FEW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT      = 2'd3;

  // datapath operation issued by the controller each cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_RD_PI,
    OP_RD_PJ,
    OP_K_STEP,
    OP_RD_FINAL
  } mco_op_t;

  typedef enum logic [1:0] {
    RES_NORMAL,
    RES_OVERFLOW,
    RES_FEW
  } mco_res_t;

  typedef struct packed {
    mco_op_t  op;
    logic     k_first;
    logic     k_last;
    logic     diag_wr;
    logic     dim_wr;
    logic     res_ld;
    mco_res_t res_kind;
  } mco_cmd_t;

  typedef struct packed {
    logic cell_done;
  } mco_sts_t;

endpackage

### hdl/mco_dpath.sv
// datapath: dimension store, cost and split tables, multiply-add pipeline,
// best-split compare and result register; driven by mco_ctrl, uses mco_pkg
`timescale 1ns / 1ps

module mco_dpath
  import mco_pkg::*;
#(
  parameter int MAX_MATRICES = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  mco_cmd_t                                 cmd,
  input  logic [DIM_W-1:0]                         dim_wdata,
  input  logic [$clog2(MAX_MATRICES+1)-1:0]        dim_waddr,
  input  logic [$clog2(MAX_MATRICES+1)-1:0]        dim_raddr,
  input  logic [$clog2(MAX_MATRICES*MAX_MATRICES)-1:0] cost_raddr_a,
  input  logic [$clog2(MAX_MATRICES*MAX_MATRICES)-1:0] cost_raddr_b,
  input  logic [$clog2(MAX_MATRICES*MAX_MATRICES)-1:0] cell_addr,
  input  logic [SPLIT_W-1:0]                       split_k,
  input  logic [COUNT_W-1:0]                       res_count,
  output mco_sts_t                                 sts,
  output logic [COST_W-1:0]                        min_cost,
  output logic [TSPLIT_W-1:0]                      top_split,
  output logic [COUNT_W-1:0]                       matrix_count,
  output logic [STATUS_W-1:0]                      status
);

  localparam int NDIM  = MAX_MATRICES + 1;
  localparam int TSIZE = MAX_MATRICES * MAX_MATRICES;

  logic [DIM_W-1:0]   dim_mem   [NDIM];
  logic [COST_W-1:0]  cost_mem  [TSIZE];
  logic [SPLIT_W-1:0] split_mem [TSIZE];

  logic               dim_rd;
  logic               cost_rd;
  logic               cost_wr;
  logic [COST_W-1:0]  cost_wdata;
  logic [SPLIT_W-1:0] split_wdata;

  // stage 1: registered memory outputs
  logic [DIM_W-1:0]   dim_q_r;
  logic [COST_W-1:0]  ca_q_r;
  logic [COST_W-1:0]  cb_q_r;
  logic [SPLIT_W-1:0] sp_q_r;
  mco_op_t            op1_r;
  logic               first1_r;
  logic               last1_r;
  logic [SPLIT_W-1:0] k1_r;

  logic [DIM_W-1:0]   pi_r;
  logic [DIM_W-1:0]   pj_r;

  // stage 2
  logic                v2_r;
  logic                first2_r;
  logic                last2_r;
  logic [SPLIT_W-1:0]  k2_r;
  logic [2*DIM_W-1:0]  prod1_r;
  logic [COST_W:0]     csum_r;

  // stage 3
  logic                v3_r;
  logic                first3_r;
  logic                last3_r;
  logic [SPLIT_W-1:0]  k3_r;
  logic [PROD_W-1:0]   prod_r;
  logic [COST_W:0]     csum3_r;

  // stage 4
  logic                v4_r;
  logic                first4_r;
  logic                last4_r;
  logic [SPLIT_W-1:0]  k4_r;
  logic [COST_W-1:0]   t_r;
  logic [COST_W+1:0]   full_sum;
  logic [COST_W-1:0]   t_nxt;

  logic [COST_W-1:0]   best_r;
  logic [SPLIT_W-1:0]  bestk_r;
  logic                cell_wr_r;

  logic [COST_W-1:0]   min_cost_r;
  logic [TSPLIT_W-1:0] top_split_r;
  logic [COUNT_W-1:0]  matrix_count_r;
  logic [STATUS_W-1:0] status_r;

  assign dim_rd  = (cmd.op == OP_RD_PI) || (cmd.op == OP_RD_PJ) || (cmd.op == OP_K_STEP);
  assign cost_rd = (cmd.op == OP_K_STEP) || (cmd.op == OP_RD_FINAL);
  assign cost_wr = cmd.diag_wr || cell_wr_r;

  // diagonal entries are zero cost with no split
  assign cost_wdata  = cmd.diag_wr ? '0 : best_r;
  assign split_wdata = cmd.diag_wr ? '0 : bestk_r;

  always_ff @(posedge clk) begin
    if (cmd.dim_wr) begin
      dim_mem[dim_waddr] <= dim_wdata;
    end
    if (dim_rd) begin
      dim_q_r <= dim_mem[dim_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cost_wr) begin
      cost_mem[cell_addr]  <= cost_wdata;
      split_mem[cell_addr] <= split_wdata;
    end
    if (cost_rd) begin
      ca_q_r <= cost_mem[cost_raddr_a];
      cb_q_r <= cost_mem[cost_raddr_b];
      sp_q_r <= split_mem[cost_raddr_a];
    end
  end

  always_comb begin
    full_sum = (COST_W+2)'(csum3_r) + (COST_W+2)'(prod_r);
    if (full_sum > (COST_W+2)'(COST_MAX)) begin
      t_nxt = COST_MAX;
    end else begin
      t_nxt = full_sum[COST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op1_r     <= OP_NONE;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      cell_wr_r <= 1'b0;
    end else begin
      op1_r     <= cmd.op;
      v2_r      <= (op1_r == OP_K_STEP);
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      cell_wr_r <= v4_r && last4_r;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= cmd.k_first;
    last1_r  <= cmd.k_last;
    k1_r     <= split_k;

    if (op1_r == OP_RD_PI) begin
      pi_r <= dim_q_r;
    end
    if (op1_r == OP_RD_PJ) begin
      pj_r <= dim_q_r;
    end

    first2_r <= first1_r;
    last2_r  <= last1_r;
    k2_r     <= k1_r;
    prod1_r  <= (2*DIM_W)'(pi_r) * (2*DIM_W)'(dim_q_r);
    csum_r   <= {1'b0, ca_q_r} + {1'b0, cb_q_r};

    first3_r <= first2_r;
    last3_r  <= last2_r;
    k3_r     <= k2_r;
    prod_r   <= PROD_W'(prod1_r) * PROD_W'(pj_r);
    csum3_r  <= csum_r;

    first4_r <= first3_r;
    last4_r  <= last3_r;
    k4_r     <= k3_r;
    t_r      <= t_nxt;

    // strict less keeps the earliest split on a tie
    if (v4_r && (first4_r || (t_r < best_r))) begin
      best_r  <= t_r;
      bestk_r <= k4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      unique case (cmd.res_kind)
        RES_NORMAL: begin
          min_cost_r     <= ca_q_r;
          top_split_r    <= TSPLIT_W'(sp_q_r);
          matrix_count_r <= res_count;
          status_r       <= (ca_q_r == COST_MAX) ? ST_SAT : ST_OK;
        end
        RES_OVERFLOW: begin
          min_cost_r     <= '0;
          top_split_r    <= '0;
          matrix_count_r <= res_count;
          status_r       <= ST_TOO_MANY;
        end
        RES_FEW: begin
          min_cost_r     <= '0;
          top_split_r    <= '0;
          matrix_count_r <= res_count;
          status_r       <= ST_TOO_FEW;
        end
        default: begin
          min_cost_r     <= '0;
          top_split_r    <= '0;
          matrix_count_r <= res_count;
          status_r       <= ST_TOO_FEW;
        end
      endcase
    end
  end

  assign sts.cell_done = cell_wr_r;
  assign min_cost      = min_cost_r;
  assign top_split     = top_split_r;
  assign matrix_count  = matrix_count_r;
  assign status        = status_r;

  a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.diag_wr && cell_wr_r))
    else $error("diagonal write collides with cell write");

  a_wr_after_last_k: assert property (@(posedge clk) disable iff (!rst_n)
    cell_wr_r |-> $past(cmd.op == OP_K_STEP && cmd.k_last, 5))
    else $error("cell write without a closing split step");

endmodule

### hdl/mco_ctrl.sv
// controller: input/output handshake, load counting and the sequencer that
// walks chain length, start row and split point; uses mco_pkg
`timescale 1ns / 1ps

module mco_ctrl
  import mco_pkg::*;
#(
  parameter int MAX_MATRICES = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic                                     in_tlast,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output mco_cmd_t                                 cmd,
  input  mco_sts_t                                 sts,
  output logic [$clog2(MAX_MATRICES+1)-1:0]        dim_waddr,
  output logic [$clog2(MAX_MATRICES+1)-1:0]        dim_raddr,
  output logic [$clog2(MAX_MATRICES*MAX_MATRICES)-1:0] cost_raddr_a,
  output logic [$clog2(MAX_MATRICES*MAX_MATRICES)-1:0] cost_raddr_b,
  output logic [$clog2(MAX_MATRICES*MAX_MATRICES)-1:0] cell_addr,
  output logic [SPLIT_W-1:0]                       split_k,
  output logic [COUNT_W-1:0]                       res_count
);

  localparam int NDIM = MAX_MATRICES + 1;
  localparam int LW   = $clog2(NDIM + 1);
  localparam int NW   = $clog2(MAX_MATRICES + 1);
  localparam int IW   = $clog2(MAX_MATRICES);
  localparam int DAW  = $clog2(NDIM);
  localparam int AW   = $clog2(MAX_MATRICES * MAX_MATRICES);
  localparam logic [AW-1:0] M_A = AW'(MAX_MATRICES);

  typedef enum logic [2:0] {
    S_LOAD,
    S_DIAG,
    S_CELL_PI,
    S_CELL_PJ,
    S_K_ISSUE,
    S_CELL_WAIT,
    S_FINAL_RD,
    S_EMIT
  } state_t;

  state_t          st_r;
  logic [LW-1:0]   load_cnt_r;
  logic            ovf_r;
  logic [NW-1:0]   n_r;
  logic [IW-1:0]   span_r;
  logic [IW-1:0]   i0_r;
  logic [IW-1:0]   k0_r;
  mco_res_t        res_kind_r;
  logic            out_valid_r;

  logic            in_acc;
  logic            room;
  logic [LW-1:0]   lc_nxt;
  logic            ovf_nxt;
  logic            out_free;
  logic [IW-1:0]   j0;
  logic [IW-1:0]   k0_p1;
  logic [NW-1:0]   n_m1;
  logic            i_end;
  logic            j_end;
  logic            span_end;
  logic [AW-1:0]   k_addr_a;
  logic [IW+SPLIT_W-1:0] k_ext;
  logic [NW+COUNT_W-1:0] n_ext;

  assign in_tready  = (st_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  // dimensions past the store depth are dropped and flagged
  assign room    = (load_cnt_r < LW'(NDIM));
  assign lc_nxt  = load_cnt_r + LW'(room);
  assign ovf_nxt = ovf_r || !room;

  assign j0       = i0_r + span_r;
  assign k0_p1    = k0_r + IW'(1);
  assign n_m1     = n_r - NW'(1);
  assign i_end    = (NW'(i0_r) == n_m1);
  assign j_end    = (NW'(j0) == n_m1);
  assign span_end = (NW'(span_r) == n_m1);

  assign cell_addr    = AW'(i0_r) * M_A + AW'(j0);
  assign k_addr_a     = AW'(i0_r) * M_A + AW'(k0_r);
  assign cost_raddr_a = (st_r == S_FINAL_RD) ? cell_addr : k_addr_a;
  assign cost_raddr_b = AW'(k0_p1) * M_A + AW'(j0);
  assign dim_waddr    = load_cnt_r[DAW-1:0];

  // split point is stored 1-based, low four bits only
  assign k_ext   = (IW+SPLIT_W)'(k0_r) + (IW+SPLIT_W)'(1);
  assign split_k = k_ext[SPLIT_W-1:0];

  assign n_ext = (NW+COUNT_W)'(n_r);

  always_comb begin
    unique case (res_kind_r)
      RES_NORMAL:   res_count = n_ext[COUNT_W-1:0];
      RES_OVERFLOW: res_count = COUNT_W'(MAX_MATRICES);
      RES_FEW:      res_count = '0;
      default:      res_count = '0;
    endcase
  end

  always_comb begin
    unique case (st_r)
      S_CELL_PI: dim_raddr = DAW'(i0_r);
      S_CELL_PJ: dim_raddr = DAW'(j0) + DAW'(1);
      S_K_ISSUE: dim_raddr = DAW'(k0_p1);
      default:   dim_raddr = '0;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.res_kind = res_kind_r;
    unique case (st_r)
      S_LOAD:      cmd.dim_wr = in_acc && room;
      S_DIAG:      cmd.diag_wr = 1'b1;
      S_CELL_PI:   cmd.op = OP_RD_PI;
      S_CELL_PJ:   cmd.op = OP_RD_PJ;
      S_K_ISSUE: begin
        cmd.op      = OP_K_STEP;
        cmd.k_first = (k0_r == i0_r);
        cmd.k_last  = (k0_p1 == j0);
      end
      S_CELL_WAIT: cmd.op = OP_NONE;
      S_FINAL_RD:  cmd.op = OP_RD_FINAL;
      S_EMIT:      cmd.res_ld = out_free;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_LOAD;
      load_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      n_r         <= '0;
      span_r      <= '0;
      i0_r        <= '0;
      k0_r        <= '0;
      res_kind_r  <= RES_NORMAL;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_LOAD: begin
          if (in_acc) begin
            load_cnt_r <= lc_nxt;
            ovf_r      <= ovf_nxt;
            if (in_tlast) begin
              priority if (ovf_nxt) begin
                res_kind_r <= RES_OVERFLOW;
                st_r       <= S_EMIT;
              end else if (lc_nxt < LW'(2)) begin
                res_kind_r <= RES_FEW;
                st_r       <= S_EMIT;
              end else begin
                res_kind_r <= RES_NORMAL;
                n_r        <= NW'(lc_nxt - LW'(1));
                i0_r       <= '0;
                span_r     <= '0;
                st_r       <= S_DIAG;
              end
            end
          end
        end
        S_DIAG: begin
          if (i_end) begin
            i0_r <= '0;
            if (n_r == NW'(1)) begin
              st_r <= S_FINAL_RD;
            end else begin
              span_r <= IW'(1);
              st_r   <= S_CELL_PI;
            end
          end else begin
            i0_r <= i0_r + IW'(1);
          end
        end
        S_CELL_PI: begin
          k0_r <= i0_r;
          st_r <= S_CELL_PJ;
        end
        S_CELL_PJ: begin
          st_r <= S_K_ISSUE;
        end
        S_K_ISSUE: begin
          if (k0_p1 == j0) begin
            st_r <= S_CELL_WAIT;
          end else begin
            k0_r <= k0_p1;
          end
        end
        S_CELL_WAIT: begin
          if (sts.cell_done) begin
            if (j_end) begin
              if (span_end) begin
                st_r <= S_FINAL_RD;
              end else begin
                span_r <= span_r + IW'(1);
                i0_r   <= '0;
                st_r   <= S_CELL_PI;
              end
            end else begin
              i0_r <= i0_r + IW'(1);
              st_r <= S_CELL_PI;
            end
          end
        end
        S_FINAL_RD: begin
          st_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            load_cnt_r  <= '0;
            ovf_r       <= 1'b0;
            st_r        <= S_LOAD;
          end
        end
        default: begin
          st_r <= S_LOAD;
        end
      endcase
    end
  end

  a_res_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |=> out_tvalid)
    else $error("result loaded but not presented");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_K_ISSUE) |-> ((k0_r >= i0_r) && (k0_r < j0)))
    else $error("split point outside its sub-chain");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.cell_done |-> (st_r == S_CELL_WAIT))
    else $error("cell completion outside wait state");

  a_last_stops_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> !in_tready)
    else $error("input taken while a chain is being solved");

endmodule

### hdl/matrix_chain_order_dp_top.sv
// Matrix chain order solver. Dimensions p0..pn arrive one request per cycle on the
// input stream, tlast on pn. After the last one, the sequencer writes the n diagonal
// entries, then solves every sub-chain in order of length: it fetches the sub-chain's
// outer dimensions, issues each split point through the shared multiply-add pipeline,
// then waits for the pipeline to drain and writes the cell. A chain with too many or
// too few dimensions goes straight to its result with an error status. Cells are
// solved one at a time, since the single cost-table write port takes each finished
// cell and the next cell starts only after the drain. A finished result waits in its
// output register while the next chain loads. No items are taken while a chain is
// being solved.
// depends on mco_pkg, mco_ctrl and mco_dpath
`timescale 1ns / 1ps

module matrix_chain_order_dp_top
  import mco_pkg::*;
#(
  parameter int MAX_MATRICES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] dimension
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [51:0] min_cost, [56:52] top_split,
                                  // [61:57] matrix_count, [63:62] status
);

  localparam int DAW = $clog2(MAX_MATRICES + 1);
  localparam int AW  = $clog2(MAX_MATRICES * MAX_MATRICES);

  mco_cmd_t            cmd;
  mco_sts_t            sts;
  logic [DAW-1:0]      dim_waddr;
  logic [DAW-1:0]      dim_raddr;
  logic [AW-1:0]       cost_raddr_a;
  logic [AW-1:0]       cost_raddr_b;
  logic [AW-1:0]       cell_addr;
  logic [SPLIT_W-1:0]  split_k;
  logic [COUNT_W-1:0]  res_count;
  logic [COST_W-1:0]   min_cost;
  logic [TSPLIT_W-1:0] top_split;
  logic [COUNT_W-1:0]  matrix_count;
  logic [STATUS_W-1:0] status;

  mco_ctrl #(
    .MAX_MATRICES (MAX_MATRICES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .cmd          (cmd),
    .sts          (sts),
    .dim_waddr    (dim_waddr),
    .dim_raddr    (dim_raddr),
    .cost_raddr_a (cost_raddr_a),
    .cost_raddr_b (cost_raddr_b),
    .cell_addr    (cell_addr),
    .split_k      (split_k),
    .res_count    (res_count)
  );

  mco_dpath #(
    .MAX_MATRICES (MAX_MATRICES)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .dim_wdata    (in_tdata),
    .dim_waddr    (dim_waddr),
    .dim_raddr    (dim_raddr),
    .cost_raddr_a (cost_raddr_a),
    .cost_raddr_b (cost_raddr_b),
    .cell_addr    (cell_addr),
    .split_k      (split_k),
    .res_count    (res_count),
    .sts          (sts),
    .min_cost     (min_cost),
    .top_split    (top_split),
    .matrix_count (matrix_count),
    .status       (status)
  );

  assign out_tdata = {status, matrix_count, top_split, min_cost};

endmodule
